// ===== sv/tsc_pkg.sv =====
`default_nettype none

package tsc_pkg;

    // Station bitmap size and derived widths
    localparam int NUM_STATIONS = 1024;
    localparam int STN_AW       = $clog2(NUM_STATIONS);
    localparam int STN_CW       = $clog2(NUM_STATIONS + 1);

    // Field widths fixed by the interface
    localparam int LVL_W = 4;
    localparam int CNT_W = 11;

    // Counters saturate at the largest value the field holds
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // Ready count saturates here: two or more is a collision
    localparam logic [1:0] SAT_READY = 2'd2;

    // Work stack: one pending upper half per tree level
    localparam int STK_DEPTH = STN_AW + 1;
    localparam int STK_IW    = $clog2(STK_DEPTH);
    localparam int STK_PW    = $clog2(STK_DEPTH + 1);

    typedef struct packed {
        logic [CNT_W-1:0] idle;
        logic [CNT_W-1:0] success;
        logic [CNT_W-1:0] fail;
    } tsc_counts_t;

    typedef struct packed {
        logic              en;
        logic [STN_AW-1:0] addr;
    } tsc_rd_req_t;

    typedef struct packed {
        logic [STN_AW-1:0] base;
        logic [STN_CW-1:0] len;
        logic [LVL_W-1:0]  depth;
    } tsc_node_t;

    typedef struct packed {
        logic start;
        logic ack;
    } tsc_walk_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } tsc_walk_status_t;

    typedef enum logic [2:0] {
        W_IDLE,
        W_NODE,
        W_READ,
        W_ACC,
        W_POP,
        W_DONE
    } tsc_walk_state_t;

    typedef enum logic {
        TOP_LOAD,
        TOP_WALK
    } tsc_top_state_t;

endpackage

`default_nettype wire

// ===== sv/tsc_if.sv =====
`default_nettype none

// Station bit request channel
interface tsc_station_if ();
    logic valid;
    logic ready;
    logic ready_req;
    logic last;

    modport source (output valid, output ready_req, output last, input ready);
    modport sink   (input valid, input ready_req, input last, output ready);
endinterface

// Slot totals result channel
interface tsc_slots_if import tsc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] idle_slots;
    logic [CNT_W-1:0] success_slots;
    logic [CNT_W-1:0] fail_slots;

    modport source (output valid, output idle_slots, output success_slots,
                    output fail_slots, input ready);
    modport sink   (input valid, input idle_slots, input success_slots,
                    input fail_slots, output ready);
endinterface

// Configuration write channel
interface tsc_cfg_if import tsc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [LVL_W-1:0] start_level;

    modport source (output valid, output start_level, input ready);
    modport sink   (input valid, input start_level, output ready);
endinterface

`default_nettype wire

// ===== sv/tsc_bitmap.sv =====
`default_nettype none

module tsc_bitmap import tsc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [STN_AW-1:0] wr_addr,
    input  wire logic              wr_bit,
    input  wire logic [STN_CW-1:0] fill,
    input  wire tsc_rd_req_t       rd,
    output logic                   rd_bit
);

    logic mem [NUM_STATIONS];
    logic rd_bit_reg;

    // Write port: one station bit per request
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_bit;
        end
    end

    // Registered read; entries at or above the fill count read as idle
    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_bit_reg <= mem[rd.addr] & (STN_CW'(rd.addr) < fill);
        end
    end

    assign rd_bit = rd_bit_reg;

endmodule

`default_nettype wire

// ===== sv/tsc_walker.sv =====
`default_nettype none

module tsc_walker import tsc_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [LVL_W-1:0] start_level,
    input  wire tsc_walk_ctrl_t   ctrl,
    output tsc_walk_status_t      status,
    output tsc_rd_req_t           rd,
    input  wire logic             rd_bit,
    output tsc_counts_t           counts
);

    tsc_walk_state_t   state_reg, state_next;
    tsc_node_t         node_reg;
    tsc_node_t         stack_reg [STK_DEPTH];
    logic [STK_PW-1:0] sp_reg;
    logic [STN_CW-1:0] ptr_reg;
    logic [1:0]        cnt_reg;
    tsc_counts_t       counts_reg;

    logic [STN_CW-1:0] lo_len;
    logic [STN_CW-1:0] hi_len;
    logic [STN_CW:0]   hi_sum;
    logic [STN_CW:0]   addr_sum;
    logic [LVL_W-1:0]  child_depth;
    logic [STK_PW-1:0] sp_top;
    logic              scan_end;
    logic              group_split;
    logic              stack_empty;

    logic do_init, do_split, fail_split, do_probe, do_issue, do_acc, do_pop;
    logic bump_idle, bump_succ, bump_fail;

    // Node arithmetic: halves, upper base, scan address
    assign lo_len      = node_reg.len >> 1;
    assign hi_len      = node_reg.len - lo_len;
    assign hi_sum      = (STN_CW+1)'(node_reg.base) + (STN_CW+1)'(lo_len);
    assign addr_sum    = (STN_CW+1)'(node_reg.base) + (STN_CW+1)'(ptr_reg);
    assign child_depth = fail_split ? '0 : node_reg.depth - LVL_W'(1);
    assign sp_top      = sp_reg - STK_PW'(1);
    assign scan_end    = (ptr_reg == node_reg.len) || (cnt_reg == SAT_READY);
    assign group_split = (node_reg.depth != '0) && (node_reg.len > STN_CW'(1));
    assign stack_empty = (sp_reg == '0);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            W_IDLE:
            begin
                if (ctrl.start)
                begin
                    state_next = W_NODE;
                end
            end
            W_NODE:
            begin
                if (!group_split)
                begin
                    state_next = W_READ;
                end
            end
            W_READ:
            begin
                if (!scan_end)
                begin
                    state_next = W_ACC;
                end
                else if (cnt_reg == SAT_READY)
                begin
                    state_next = W_NODE;
                end
                else
                begin
                    state_next = W_POP;
                end
            end
            W_ACC:
            begin
                state_next = W_READ;
            end
            W_POP:
            begin
                state_next = stack_empty ? W_DONE : W_NODE;
            end
            W_DONE:
            begin
                if (ctrl.ack)
                begin
                    state_next = W_IDLE;
                end
            end
            default:
            begin
                state_next = W_IDLE;
            end
        endcase
    end

    // Control outputs
    always_comb
    begin
        do_init    = 1'b0;
        do_split   = 1'b0;
        fail_split = 1'b0;
        do_probe   = 1'b0;
        do_issue   = 1'b0;
        do_acc     = 1'b0;
        do_pop     = 1'b0;
        bump_idle  = 1'b0;
        bump_succ  = 1'b0;
        bump_fail  = 1'b0;
        status     = '0;
        case (state_reg)
            W_IDLE:
            begin
                do_init = ctrl.start;
            end
            W_NODE:
            begin
                status.busy = 1'b1;
                do_split    = group_split;
                do_probe    = !group_split;
            end
            W_READ:
            begin
                status.busy = 1'b1;
                if (!scan_end)
                begin
                    do_issue = 1'b1;
                end
                else
                begin
                    case (cnt_reg)
                        2'd0:
                        begin
                            bump_idle = 1'b1;
                        end
                        2'd1:
                        begin
                            bump_succ = 1'b1;
                        end
                        default:
                        begin
                            bump_fail  = 1'b1;
                            do_split   = 1'b1;
                            fail_split = 1'b1;
                        end
                    endcase
                end
            end
            W_ACC:
            begin
                status.busy = 1'b1;
                do_acc      = 1'b1;
            end
            W_POP:
            begin
                status.busy = 1'b1;
                do_pop      = !stack_empty;
            end
            W_DONE:
            begin
                status.busy = 1'b1;
                status.done = 1'b1;
            end
            default:
            begin
                status = '0;
            end
        endcase
    end

    assign rd.en   = do_issue;
    assign rd.addr = addr_sum[STN_AW-1:0];
    assign counts  = counts_reg;

    // Control state: sequencer, stack pointer, slot counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= W_IDLE;
            sp_reg     <= '0;
            counts_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (do_init)
            begin
                sp_reg     <= '0;
                counts_reg <= '0;
            end
            if (do_split)
            begin
                sp_reg <= sp_reg + STK_PW'(1);
            end
            if (do_pop)
            begin
                sp_reg <= sp_top;
            end
            if (bump_idle && (counts_reg.idle != CNT_MAX))
            begin
                counts_reg.idle <= counts_reg.idle + CNT_W'(1);
            end
            if (bump_succ && (counts_reg.success != CNT_MAX))
            begin
                counts_reg.success <= counts_reg.success + CNT_W'(1);
            end
            if (bump_fail && (counts_reg.fail != CNT_MAX))
            begin
                counts_reg.fail <= counts_reg.fail + CNT_W'(1);
            end
        end
    end

    // Node, scan and stack datapath
    always_ff @(posedge clk)
    begin
        if (do_init)
        begin
            node_reg.base  <= '0;
            node_reg.len   <= STN_CW'(NUM_STATIONS);
            node_reg.depth <= start_level;
        end
        if (do_split)
        begin
            stack_reg[sp_reg[STK_IW-1:0]] <= '{base:  hi_sum[STN_AW-1:0],
                                               len:   hi_len,
                                               depth: child_depth};
            node_reg.len   <= lo_len;
            node_reg.depth <= child_depth;
        end
        if (do_pop)
        begin
            node_reg <= stack_reg[sp_top[STK_IW-1:0]];
        end
        if (do_probe)
        begin
            ptr_reg <= '0;
            cnt_reg <= '0;
        end
        if (do_acc)
        begin
            ptr_reg <= ptr_reg + STN_CW'(1);
            if (rd_bit)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
        end
    end

    // Checks
    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= STK_PW'(STK_DEPTH))
        else $error("work stack overflow");

    a_cnt_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == W_READ || state_reg == W_ACC) |-> cnt_reg <= SAT_READY)
        else $error("ready count beyond saturation");

    a_acc_after_issue: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == W_ACC) |-> ($past(state_reg) == W_READ && $past(rd.en)))
        else $error("accumulate without a read issued");

    a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == W_ACC) |-> ptr_reg < node_reg.len)
        else $error("scan pointer beyond node");

endmodule

`default_nettype wire

// ===== sv/tree_splitting_slot_counter_top.sv =====
// Loading: one station request per cycle; ready stays high until the request marked last.
// Resolution: after the last request the block walks the splitting tree and takes no request;
//   each probed node is scanned one bit at a time through the bitmap read port.
// The totals enter the output register once the walk is done and the output is free.
// Reset (rst_n, asynchronous, active low): bitmap empty, counters zero, start_level 0.
`default_nettype none

module tree_splitting_slot_counter_top import tsc_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    tsc_station_if.sink station,
    tsc_slots_if.source slots,
    tsc_cfg_if.sink     cfg
);

    tsc_top_state_t    state_reg, state_next;
    logic [STN_CW-1:0] fill_reg;
    logic [LVL_W-1:0]  start_level_reg;
    logic              out_valid_reg;
    tsc_counts_t       out_reg;

    logic              accept;
    logic              wr_en;
    logic              rd_bit;
    tsc_rd_req_t       rd;
    tsc_walk_ctrl_t    walk_ctrl;
    tsc_walk_status_t  walk_status;
    tsc_counts_t       counts;

    // Bitmap store
    tsc_bitmap u_bitmap (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (fill_reg[STN_AW-1:0]),
        .wr_bit  (station.ready_req),
        .fill    (fill_reg),
        .rd      (rd),
        .rd_bit  (rd_bit)
    );

    // Tree walk sequencer
    tsc_walker u_walker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start_level (start_level_reg),
        .ctrl        (walk_ctrl),
        .status      (walk_status),
        .rd          (rd),
        .rd_bit      (rd_bit),
        .counts      (counts)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            TOP_LOAD:
            begin
                if (walk_ctrl.start)
                begin
                    state_next = TOP_WALK;
                end
            end
            TOP_WALK:
            begin
                if (walk_ctrl.ack)
                begin
                    state_next = TOP_LOAD;
                end
            end
            default:
            begin
                state_next = TOP_LOAD;
            end
        endcase
    end

    // Handshake and walk control
    always_comb
    begin
        station.ready   = 1'b0;
        walk_ctrl.start = 1'b0;
        walk_ctrl.ack   = 1'b0;
        case (state_reg)
            TOP_LOAD:
            begin
                station.ready   = 1'b1;
                walk_ctrl.start = station.valid && station.last;
            end
            TOP_WALK:
            begin
                walk_ctrl.ack = walk_status.done && (!out_valid_reg || slots.ready);
            end
            default:
            begin
                station.ready = 1'b0;
            end
        endcase
    end

    assign accept          = station.valid && station.ready;
    assign wr_en           = accept && (fill_reg < STN_CW'(NUM_STATIONS));
    assign cfg.ready       = 1'b1;

    assign slots.valid         = out_valid_reg;
    assign slots.idle_slots    = out_reg.idle;
    assign slots.success_slots = out_reg.success;
    assign slots.fail_slots    = out_reg.fail;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= TOP_LOAD;
            fill_reg        <= '0;
            start_level_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid)
            begin
                start_level_reg <= cfg.start_level;
            end
            if (wr_en)
            begin
                fill_reg <= fill_reg + STN_CW'(1);
            end
            if (walk_ctrl.ack)
            begin
                fill_reg      <= '0;
                out_valid_reg <= 1'b1;
            end
            else if (slots.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (walk_ctrl.ack)
        begin
            out_reg <= counts;
        end
    end

endmodule

`default_nettype wire
